/* hw/rtl/cia_pkg.sv */
// shared types and codes for the checked integer alu
`default_nettype none
package cia_pkg;

  localparam int DATA_WIDTH_DEFAULT = 32;
  localparam int VALUE_W = 32;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_LT  = 3'd4;
  localparam logic [2:0] OP_GT  = 3'd5;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_LHS  = 3'd1;
  localparam logic [2:0] ERR_RHS  = 3'd2;
  localparam logic [2:0] ERR_OVF  = 3'd3;
  localparam logic [2:0] ERR_DIV0 = 3'd4;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] lhs;
    logic signed [31:0] rhs;
    logic               lhs_is_number;
    logic               rhs_is_number;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               is_boolean;
    logic [2:0]         error_code;
  } rsp_t;

  // per-item control carried down the pipeline
  typedef struct packed {
    logic [2:0] op;
    logic [2:0] err;
    logic       neg;
  } ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/cia_front.sv */
// decode stage: operand checks, add/sub/compare, magnitudes for mul and div
`default_nettype none
module cia_front #(
  parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  req_vld,
  input  wire cia_pkg::req_t         req,
  output logic                       vld,
  output cia_pkg::ctl_t              ctl,
  output logic [cia_pkg::VALUE_W-1:0] simple,
  output logic [DATA_WIDTH-1:0]      mag_a,
  output logic [DATA_WIDTH-1:0]      mag_b
);
  localparam int W = DATA_WIDTH;

  logic signed [W-1:0] n;
  logic signed [W-1:0] m;
  logic [W:0]          sum;
  logic [W:0]          diff;
  logic                add_ovf;
  logic                sub_ovf;
  logic                lt;
  logic                gt;
  logic                n_min;
  logic                m_neg1;
  logic                m_zero;
  cia_pkg::ctl_t       ctl_next;
  logic [cia_pkg::VALUE_W-1:0] simple_next;
  logic [W-1:0]        mag_a_next;
  logic [W-1:0]        mag_b_next;

  always_comb begin
    n       = W'($unsigned(req.lhs));
    m       = W'($unsigned(req.rhs));
    sum     = {n[W-1], n} + {m[W-1], m};
    diff    = {n[W-1], n} - {m[W-1], m};
    add_ovf = sum[W] ^ sum[W-1];
    sub_ovf = diff[W] ^ diff[W-1];
    lt      = n < m;
    gt      = n > m;
    n_min   = n == {1'b1, {(W-1){1'b0}}};
    m_neg1  = &m;
    m_zero  = m == '0;
    mag_a_next = n[W-1] ? (~n + 1'b1) : n;
    mag_b_next = m[W-1] ? (~m + 1'b1) : m;

    ctl_next.op  = req.req_type;
    ctl_next.neg = n[W-1] ^ m[W-1];
    ctl_next.err = cia_pkg::ERR_NONE;
    if (!req.lhs_is_number) begin
      ctl_next.err = cia_pkg::ERR_LHS;
    end else if (!req.rhs_is_number) begin
      ctl_next.err = cia_pkg::ERR_RHS;
    end else begin
      case (req.req_type)
        cia_pkg::OP_ADD: if (add_ovf) ctl_next.err = cia_pkg::ERR_OVF;
        cia_pkg::OP_SUB: if (sub_ovf) ctl_next.err = cia_pkg::ERR_OVF;
        cia_pkg::OP_DIV: begin
          if (n_min && m_neg1) ctl_next.err = cia_pkg::ERR_OVF;
          else if (m_zero) ctl_next.err = cia_pkg::ERR_DIV0;
        end
        default: ctl_next.err = cia_pkg::ERR_NONE;
      endcase
    end

    case (req.req_type)
      cia_pkg::OP_ADD: simple_next = cia_pkg::VALUE_W'($signed(sum[W-1:0]));
      cia_pkg::OP_SUB: simple_next = cia_pkg::VALUE_W'($signed(diff[W-1:0]));
      cia_pkg::OP_LT:  simple_next = cia_pkg::VALUE_W'(lt);
      cia_pkg::OP_GT:  simple_next = cia_pkg::VALUE_W'(gt);
      default:         simple_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= req_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl    <= ctl_next;
      simple <= simple_next;
      mag_a  <= mag_a_next;
      mag_b  <= mag_b_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/cia_div_cell.sv */
// one restoring division step; cells are chained, one quotient bit each
`default_nettype none
module cia_div_cell #(
  parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEFAULT,
  parameter int SIDE_W     = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_vld,
  input  wire logic [DATA_WIDTH-1:0] in_rem,
  input  wire logic [DATA_WIDTH-1:0] in_dvd,
  input  wire logic [DATA_WIDTH-1:0] in_dvs,
  input  wire logic [SIDE_W-1:0]     in_side,
  output logic                       out_vld,
  output logic [DATA_WIDTH-1:0]      out_rem,
  output logic [DATA_WIDTH-1:0]      out_dvd,
  output logic [DATA_WIDTH-1:0]      out_dvs,
  output logic [SIDE_W-1:0]          out_side
);
  localparam int W = DATA_WIDTH;

  logic [W:0]   trial;
  logic         qbit;
  logic [W-1:0] rem_next;
  logic [W-1:0] dvd_next;

  always_comb begin
    trial    = {in_rem, in_dvd[W-1]} - {1'b0, in_dvs};
    qbit     = !trial[W];
    rem_next = qbit ? trial[W-1:0] : {in_rem[W-2:0], in_dvd[W-1]};
    // quotient bits shift in behind the dividend bits
    dvd_next = {in_dvd[W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_next;
      out_dvd  <= dvd_next;
      out_dvs  <= in_dvs;
      out_side <= in_side;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/checked_integer_alu_floor_div.sv */
// Checked signed ALU with exact floor division.
// Pipeline: an accepted request beat passes through the decode stage, three multiplier
// stages, one divider cell per quotient bit and the output register to its response beat.
// Throughput: one beat per cycle; the whole pipeline advances only when the output
// register is empty or its beat is taken.
// Reset clears all stage valid bits; payload registers are not reset.
`default_nettype none
module checked_integer_alu_floor_div #(
  parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire cia_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output cia_pkg::rsp_t      rsp
);
  localparam int W      = DATA_WIDTH;
  localparam int HW     = (W + 1) / 2;
  localparam int LW     = W - HW;
  localparam int CTL_W  = $bits(cia_pkg::ctl_t);
  localparam int VW     = cia_pkg::VALUE_W;
  localparam int SIDE_W = CTL_W + VW + 2 * W;

  logic adv;

  // decode stage
  logic          v1;
  cia_pkg::ctl_t ctl1;
  logic [VW-1:0] simple1;
  logic [W-1:0]  a1;
  logic [W-1:0]  b1;

  // multiplier stages
  logic            v2, v3, v4;
  cia_pkg::ctl_t   ctl2, ctl3, ctl4;
  logic [VW-1:0]   simple2, simple3, simple4;
  logic [W-1:0]    a2, a3, a4;
  logic [W-1:0]    b2, b3, b4;
  logic [2*HW-1:0] pp_ll;
  logic [W-1:0]    pp_lh;
  logic [W-1:0]    pp_hl;
  logic [2*LW-1:0] pp_hh;
  logic [W:0]      mid;
  logic [2*W-1:0]  cat;
  logic [2*W-1:0]  prod;

  // divider chain
  logic              cv   [W+1];
  logic [W-1:0]      crem [W+1];
  logic [W-1:0]      cdvd [W+1];
  logic [W-1:0]      cdvs [W+1];
  logic [SIDE_W-1:0] cside[W+1];

  // result stage
  cia_pkg::ctl_t  ctl_f;
  logic [VW-1:0]  simple_f;
  logic [2*W-1:0] p_f;
  logic           mul_ovf;
  logic [W-1:0]   mul_val;
  logic [W-1:0]   q0;
  logic           rem_nz;
  logic [W-1:0]   div_val;
  cia_pkg::rsp_t  rsp_next;

  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = adv;

  cia_front #(.DATA_WIDTH(W)) u_front (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .req_vld(req_valid),
    .req    (req),
    .vld    (v1),
    .ctl    (ctl1),
    .simple (simple1),
    .mag_a  (a1),
    .mag_b  (b1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // partial products on half-width magnitudes
      pp_ll   <= a1[HW-1:0] * b1[HW-1:0];
      pp_lh   <= a1[HW-1:0] * b1[W-1:HW];
      pp_hl   <= a1[W-1:HW] * b1[HW-1:0];
      pp_hh   <= a1[W-1:HW] * b1[W-1:HW];
      ctl2    <= ctl1;
      simple2 <= simple1;
      a2      <= a1;
      b2      <= b1;

      mid     <= {1'b0, pp_lh} + {1'b0, pp_hl};
      cat     <= {pp_hh, pp_ll};
      ctl3    <= ctl2;
      simple3 <= simple2;
      a3      <= a2;
      b3      <= b2;

      prod    <= cat + ({{(W-1){1'b0}}, mid} << HW);
      ctl4    <= ctl3;
      simple4 <= simple3;
      a4      <= a3;
      b4      <= b3;
    end
  end

  assign cv[0]    = v4;
  assign crem[0]  = '0;
  assign cdvd[0]  = a4;
  assign cdvs[0]  = b4;
  assign cside[0] = {ctl4, simple4, prod};

  for (genvar i = 0; i < W; i++) begin : g_cell
    cia_div_cell #(.DATA_WIDTH(W), .SIDE_W(SIDE_W)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .in_vld  (cv[i]),
      .in_rem  (crem[i]),
      .in_dvd  (cdvd[i]),
      .in_dvs  (cdvs[i]),
      .in_side (cside[i]),
      .out_vld (cv[i+1]),
      .out_rem (crem[i+1]),
      .out_dvd (cdvd[i+1]),
      .out_dvs (cdvs[i+1]),
      .out_side(cside[i+1])
    );
  end

  always_comb begin
    ctl_f    = cia_pkg::ctl_t'(cside[W][SIDE_W-1 -: CTL_W]);
    simple_f = cside[W][2*W+VW-1 -: VW];
    p_f      = cside[W][2*W-1:0];
    // negative products may reach one past the positive limit
    mul_ovf  = ctl_f.neg ? ((|p_f[2*W-1:W]) || (p_f[W-1] && (|p_f[W-2:0])))
                         : (|p_f[2*W-1:W-1]);
    mul_val  = ctl_f.neg ? (~p_f[W-1:0] + 1'b1) : p_f[W-1:0];
    q0       = cdvd[W];
    rem_nz   = |crem[W];
    // floor: -q0 - 1 is ~q0 when the division is inexact
    div_val  = ctl_f.neg ? (rem_nz ? ~q0 : (~q0 + 1'b1)) : q0;

    rsp_next.error_code = ctl_f.err;
    if (ctl_f.err == cia_pkg::ERR_NONE && ctl_f.op == cia_pkg::OP_MUL && mul_ovf) begin
      rsp_next.error_code = cia_pkg::ERR_OVF;
    end
    rsp_next.is_boolean = 1'b0;
    rsp_next.value      = '0;
    if (rsp_next.error_code == cia_pkg::ERR_NONE) begin
      case (ctl_f.op)
        cia_pkg::OP_ADD, cia_pkg::OP_SUB: rsp_next.value = simple_f;
        cia_pkg::OP_MUL: rsp_next.value = VW'($signed(mul_val));
        cia_pkg::OP_DIV: rsp_next.value = VW'($signed(div_val));
        cia_pkg::OP_LT, cia_pkg::OP_GT: begin
          rsp_next.value      = simple_f;
          rsp_next.is_boolean = 1'b1;
        end
        default: rsp_next.value = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= cv[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp <= rsp_next;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.error_code != cia_pkg::ERR_NONE |-> rsp.value == '0 && !rsp.is_boolean)
    else $error("error response carries a value");

  a_bool_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_boolean |->
      rsp.value[VW-1:1] == '0 && rsp.error_code == cia_pkg::ERR_NONE)
    else $error("comparison result is not a clean truth value");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken while pipeline is stalled");

  a_chain_exit: assert property (@(posedge clk) disable iff (rst)
    cv[W] && adv |=> rsp_valid)
    else $error("divider chain beat lost at output");

endmodule
`default_nettype wire

/* dv/testbench.sv */
// testbench for the checked integer alu: queued driver, response monitor, inline predictor
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  cia_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  cia_pkg::rsp_t rsp;

  checked_integer_alu_floor_div uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cia_pkg::req_t pending_reqs[$];
  cia_pkg::rsp_t expected_rsps[$];
  int errors = 0;
  int send_idle_pct = 18;
  int recv_idle_pct = 85;
  bit hold_rsp = 1'b0;
  bit drain_pause = 1'b0;
  bit req_accepted = 1'b0;

  function automatic cia_pkg::rsp_t alu_result(cia_pkg::req_t r);
    cia_pkg::rsp_t o;
    longint a, b, q;
    longint vmax, vmin;
    vmax = 64'sd2147483647;
    vmin = -64'sd2147483648;
    a = r.lhs;
    b = r.rhs;
    q = 0;
    o = '0;
    o.error_code = cia_pkg::ERR_NONE;
    if (!r.lhs_is_number) begin
      o.error_code = cia_pkg::ERR_LHS;
    end else if (!r.rhs_is_number) begin
      o.error_code = cia_pkg::ERR_RHS;
    end else begin
      case (r.req_type)
        cia_pkg::OP_ADD: q = a + b;
        cia_pkg::OP_SUB: q = a - b;
        cia_pkg::OP_MUL: q = a * b;
        cia_pkg::OP_DIV: begin
          if (b == 0) q = 0;
          else begin
            q = a / b;
            if ((a % b != 0) && ((a < 0) != (b < 0))) q = q - 1;
          end
        end
        cia_pkg::OP_LT: begin
          q = (a < b) ? 1 : 0;
          o.is_boolean = 1'b1;
        end
        cia_pkg::OP_GT: begin
          q = (a > b) ? 1 : 0;
          o.is_boolean = 1'b1;
        end
        default: q = 0;
      endcase
      if (q > vmax || q < vmin) o.error_code = cia_pkg::ERR_OVF;
      else if (r.req_type == cia_pkg::OP_DIV && b == 0) o.error_code = cia_pkg::ERR_DIV0;
    end
    if (o.error_code != cia_pkg::ERR_NONE) begin
      q = 0;
      o.is_boolean = 1'b0;
    end
    o.value = q[31:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("error: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver: payload held until the beat is taken
  always @(negedge clk) begin
    if (!rst) begin
      if (!req_valid || req_accepted) begin
        if (pending_reqs.size() != 0 && !drain_pause &&
            $urandom_range(99) >= send_idle_pct) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
      rsp_ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    req_accepted <= req_valid && req_ready && !rst;
    if (!rst && req_valid && req_ready) begin
      expected_rsps.push_back(alu_result(req));
    end
  end

  // monitor
  always @(posedge clk) begin
    cia_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected beat, value", rsp.value, 0);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.value !== want.value)
          report_mismatch("value", rsp.value, want.value);
        if (rsp.is_boolean !== want.is_boolean)
          report_mismatch("is_boolean", rsp.is_boolean, want.is_boolean);
        if (rsp.error_code !== want.error_code)
          report_mismatch("error_code", rsp.error_code, want.error_code);
      end
    end
  end

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return -32'sd1;
      3: return 32'sd0;
      4: return $urandom_range(20) - 10;
      5: return $signed($urandom_range(65535)) - 32768;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(logic [2:0] op, logic signed [31:0] l, logic signed [31:0] r,
                         logic ln, logic rn);
    cia_pkg::req_t x;
    x.req_type = op;
    x.lhs = l;
    x.rhs = r;
    x.lhs_is_number = ln;
    x.rhs_is_number = rn;
    pending_reqs.push_back(x);
  endtask

  task automatic add_random(int count);
    int i;
    for (i = 0; i < count; i++)
      add_req(3'($urandom_range(7)), pick_operand(), pick_operand(),
              $urandom_range(19) != 0, $urandom_range(19) != 0);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int i;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // directed corners
    add_req(cia_pkg::OP_ADD, 32'sh7fffffff, 32'sd1, 1'b1, 1'b1);
    add_req(cia_pkg::OP_ADD, 32'sh80000000, -32'sd1, 1'b1, 1'b1);
    add_req(cia_pkg::OP_ADD, 32'sh7fffffff, 32'sh80000000, 1'b1, 1'b1);
    add_req(cia_pkg::OP_SUB, 32'sh80000000, 32'sd1, 1'b1, 1'b1);
    add_req(cia_pkg::OP_SUB, 32'sd0, 32'sh80000000, 1'b1, 1'b1);
    add_req(cia_pkg::OP_SUB, -32'sd1, 32'sh80000000, 1'b1, 1'b1);
    add_req(cia_pkg::OP_MUL, 32'sh80000000, -32'sd1, 1'b1, 1'b1);
    add_req(cia_pkg::OP_MUL, 32'sh80000000, 32'sd1, 1'b1, 1'b1);
    add_req(cia_pkg::OP_MUL, 32'sd65536, 32'sd65536, 1'b1, 1'b1);
    add_req(cia_pkg::OP_MUL, -32'sd65536, 32'sd32768, 1'b1, 1'b1);
    add_req(cia_pkg::OP_MUL, 32'sd0, 32'sh80000000, 1'b1, 1'b1);
    add_req(cia_pkg::OP_DIV, 32'sh80000000, -32'sd1, 1'b1, 1'b1);
    add_req(cia_pkg::OP_DIV, 32'sd5, 32'sd0, 1'b1, 1'b1);
    add_req(cia_pkg::OP_DIV, -32'sd7, 32'sd2, 1'b1, 1'b1);
    add_req(cia_pkg::OP_DIV, 32'sd7, -32'sd2, 1'b1, 1'b1);
    add_req(cia_pkg::OP_DIV, 32'sh80000000, 32'sh7fffffff, 1'b1, 1'b1);
    add_req(cia_pkg::OP_DIV, 32'sh7fffffff, 32'sh80000000, 1'b1, 1'b1);
    add_req(cia_pkg::OP_LT, 32'sh80000000, 32'sh7fffffff, 1'b1, 1'b1);
    add_req(cia_pkg::OP_GT, 32'sh80000000, 32'sh7fffffff, 1'b1, 1'b1);
    add_req(cia_pkg::OP_LT, 32'sd3, 32'sd0, 1'b0, 1'b0);
    add_req(cia_pkg::OP_GT, 32'sd3, 32'sd0, 1'b1, 1'b0);
    add_req(3'd6, -32'sd1, -32'sd1, 1'b1, 1'b1);
    add_req(3'd7, 32'sd1, 32'sd2, 1'b1, 1'b1);
    add_random(110);
    wait_drained();

    send_idle_pct = 85;
    recv_idle_pct = 18;
    add_random(110);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(60);
    // long receiver stall so the pipeline fills and backs up its input
    hold_rsp = 1'b1;
    for (i = 0; i < 120; i++) @(posedge clk);
    hold_rsp = 1'b0;
    wait_drained();

    // sender holds off new requests while drain_pause is set, then sends the queued ones
    drain_pause = 1'b1;
    add_random(120);
    for (i = 0; i < 10; i++) @(posedge clk);
    drain_pause = 1'b0;
    wait_drained();

    for (i = 0; i < 60; i++) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("checked_integer_alu_floor_div: match");
    end else begin
      $display("checked_integer_alu_floor_div: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("checked_integer_alu_floor_div: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
